FILE: src/abt_pkg.sv
// Shared types and constants for the audio beat and pulse tracker.
// Holds the sequencer op codes, the command struct and the log curve table.
package abt_pkg;

	localparam int HISTORY_DEPTH = 30;
	localparam int MIN_BEAT_GAP  = 10;

	localparam int PTR_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int SUM_W  = 16 + $clog2(HISTORY_DEPTH);
	localparam int MUL_W  = (SUM_W + 1 > 20) ? SUM_W + 1 : 20;
	localparam int PROD_W = 2 * MUL_W;

	// floor(sum / HISTORY_DEPTH) as (sum * REC_M) >> REC_SH
	localparam int REC_SH = SUM_W + $clog2(HISTORY_DEPTH);
	localparam longint unsigned REC_M =
		((64'd1 << REC_SH) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;

	// floor(x / 3) for 18-bit x as (x * DIV3_M) >> DIV3_SH
	localparam int DIV3_SH = 20;
	localparam int DIV3_M  = ((1 << DIV3_SH) + 2) / 3;

	localparam logic [15:0] BL_DECAY   = 16'd62259; // 0.95
	localparam logic [15:0] BL_GAIN    = 16'd3277;  // 0.05
	localparam logic [19:0] BL_RESET   = 20'd6554;
	localparam logic [15:0] BEAT_FLOOR = 16'd3276;
	localparam logic [15:0] LOG_FLOOR  = 16'd655;

	localparam logic [2:0] REG_MODE   = 3'd0;
	localparam logic [2:0] REG_THRESH = 3'd1;
	localparam logic [2:0] REG_SENS   = 3'd2;
	localparam logic [2:0] REG_REACT  = 3'd3;
	localparam logic [2:0] REG_ATTACK = 3'd4;
	localparam logic [2:0] REG_DECAY  = 3'd5;
	localparam logic [2:0] REG_HUE1   = 3'd6;
	localparam logic [2:0] REG_HUE2   = 3'd7;

	localparam logic [1:0] BAND_LOW  = 2'd0;
	localparam logic [1:0] BAND_MID  = 2'd1;
	localparam logic [1:0] BAND_HIGH = 2'd2;
	localparam logic [1:0] CURVE_LIN = 2'd0;
	localparam logic [1:0] CURVE_SQ  = 2'd1;
	localparam logic [1:0] CURVE_CUB = 2'd2;

	typedef enum logic [4:0] {
		OP_NONE, OP_DIV3, OP_SEL, OP_SQ, OP_CUBE, OP_LEVEL, OP_RING, OP_AVG,
		OP_T, OP_BL, OP_T2, OP_BEAT, OP_TGT_M, OP_TGT, OP_P1, OP_P2,
		OP_PULSE, OP_HUE_M, OP_HUE
	} op_t;

	typedef struct packed {
		logic load;
		op_t  op;
		logic publish;
	} cmd_t;

	typedef logic [15:0] log_tab_t [256];

	// 0.3*ln(1+10x) via log2 by repeated squaring, saturated to 0xFFFF
	function automatic log_tab_t build_log_tab();
		log_tab_t tab;
		longint unsigned v, m, frac, lg, val;
		int e;
		for (int i = 0; i < 256; i++) begin
			v = 64'(256 + 10 * i);
			e = 8;
			for (int j = 9; j < 13; j++) begin
				if ((v >> j) != 0) e = j;
			end
			m = v << (30 - e);
			frac = 0;
			for (int k = 0; k < 24; k++) begin
				m = (m * m) >> 30;
				frac = frac << 1;
				if (m >= (64'd2 << 30)) begin
					m = m >> 1;
					frac = frac | 64'd1;
				end
			end
			lg = (64'(e - 8) << 24) | frac;
			val = (lg * 64'd893113342 + (64'd1 << 39)) >> 40;
			if (val > 64'd65535) val = 64'd65535;
			tab[i] = val[15:0];
		end
		return tab;
	endfunction

	localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

FILE: src/abt_ctrl.sv
// Sequencer for the beat tracker: steps the datapath through one op per cycle.
// Depends on abt_pkg.
module abt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output abt_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_PUB} state_t;

	state_t         state_q;
	abt_pkg::op_t   op_q;
	logic           out_valid_q;
	logic           publish;

	assign publish   = (state_q == ST_PUB) && (!out_valid_q || out_ready);
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load    = (state_q == ST_IDLE) && in_valid;
		cmd.op      = op_q;
		cmd.publish = publish;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= abt_pkg::OP_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (publish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RUN;
						op_q    <= abt_pkg::OP_DIV3;
					end
				end
				ST_RUN: begin
					if (op_q == abt_pkg::OP_HUE) begin
						state_q <= ST_PUB;
						op_q    <= abt_pkg::OP_NONE;
					end else begin
						op_q <= abt_pkg::op_t'(op_q + 5'd1);
					end
				end
				ST_PUB: begin
					if (publish) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
					op_q    <= abt_pkg::OP_NONE;
				end
			endcase
		end
	end

endmodule

FILE: src/abt_dp.sv
// Datapath for the beat tracker: config registers, energy ring, one shared
// multiplier with a product register. Depends on abt_pkg.
module abt_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  abt_pkg::cmd_t cmd,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [15:0]   cfg_data,
	input  logic [15:0]   low_band,
	input  logic [15:0]   mid_band,
	input  logic [15:0]   high_band,
	output logic [15:0]   shaped_level,
	output logic          beat_flag,
	output logic [15:0]   pulse_level,
	output logic [15:0]   hue_out
);

	localparam int SW = abt_pkg::SUM_W;
	localparam int MW = abt_pkg::MUL_W;
	localparam int PW = abt_pkg::PROD_W;
	localparam int PTW = abt_pkg::PTR_W;

	logic [3:0]  mode_q;
	logic [15:0] thr_q, att_q, dec_q, huef_q, hues_q;
	logic [10:0] sens_q;
	logic [11:0] react_q;

	logic [15:0] lo_q, mid_q, hi_q, x_q, sq_q, level_q, tgt_q, pulse_q, dabs_q, hue_q;
	logic [17:0] bsum_q;
	logic [SW-1:0] sum_q;
	logic [15:0] ring_q [abt_pkg::HISTORY_DEPTH];
	logic [PTW-1:0] ptr_q;
	logic [7:0]  frames_q;
	logic [19:0] bl_q;
	logic [18:0] t_q;
	logic [PW-1:0] acc_q, prod_q, prod_d;
	logic        beat_q, rise_q, dneg_q;
	logic [15:0] shaped_q, pls_q, hueo_q;
	logic        beat_o_q;

	logic [MW-1:0] mul_a, mul_b;
	logic        mul_en;
	logic [15:0] x_sel;
	logic [15:0] level_d;
	logic [37:0] nb_raw;
	logic [19:0] nb;
	logic [19:0] tgt_raw;
	logic [32:0] p_raw;
	logic [15:0] p_sat, p_new;
	logic signed [17:0] d_raw, d_fold;
	logic [16:0] delta;

	// shared multiplier operand select
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		case (cmd.op)
			abt_pkg::OP_DIV3: begin
				mul_a = MW'(bsum_q);
				mul_b = MW'(abt_pkg::DIV3_M);
			end
			abt_pkg::OP_SQ: begin
				mul_a = MW'(x_q);
				mul_b = MW'(x_q);
			end
			abt_pkg::OP_CUBE: begin
				mul_a = MW'(prod_q[31:16]);
				mul_b = MW'(x_q);
			end
			abt_pkg::OP_AVG: begin
				mul_a = MW'(sum_q);
				mul_b = MW'(abt_pkg::REC_M);
			end
			abt_pkg::OP_T: begin
				mul_a = MW'(prod_q[abt_pkg::REC_SH +: 16]);
				mul_b = MW'(sens_q);
			end
			abt_pkg::OP_BL: begin
				mul_a = MW'(bl_q);
				mul_b = MW'(abt_pkg::BL_DECAY);
			end
			abt_pkg::OP_T2: begin
				mul_a = MW'(t_q);
				mul_b = MW'(abt_pkg::BL_GAIN);
			end
			abt_pkg::OP_TGT_M: begin
				mul_a = MW'(level_q);
				mul_b = MW'(react_q);
			end
			abt_pkg::OP_P1: begin
				mul_a = MW'(pulse_q);
				mul_b = (tgt_q > pulse_q) ? MW'(att_q) : MW'(dec_q);
			end
			abt_pkg::OP_P2: begin
				mul_a = MW'(tgt_q);
				mul_b = MW'(17'h10000 - {1'b0, att_q});
			end
			abt_pkg::OP_HUE_M: begin
				mul_a = MW'(dabs_q);
				mul_b = MW'(pulse_q);
			end
			default: mul_en = 1'b0;
		endcase
	end

	assign prod_d = PW'(mul_a) * PW'(mul_b);

	// band pick and silence gate
	always_comb begin
		case (mode_q[1:0])
			abt_pkg::BAND_LOW:  x_sel = lo_q;
			abt_pkg::BAND_MID:  x_sel = mid_q;
			abt_pkg::BAND_HIGH: x_sel = hi_q;
			default:            x_sel = prod_q[35:20];
		endcase
		if (x_sel < thr_q) x_sel = '0;
	end

	always_comb begin
		case (mode_q[3:2])
			abt_pkg::CURVE_LIN: level_d = x_q;
			abt_pkg::CURVE_SQ:  level_d = sq_q;
			abt_pkg::CURVE_CUB: level_d = prod_q[31:16];
			default: level_d = (x_q > abt_pkg::LOG_FLOOR) ? abt_pkg::LOG_TAB[x_q[15:8]] : 16'd0;
		endcase
	end

	// adaptive threshold update, saturated to 20 bits
	assign nb_raw = 38'(acc_q) + 38'(prod_q) + 38'd32768;
	assign nb     = (nb_raw[37:16] > 22'hFFFFF) ? 20'hFFFFF : nb_raw[35:16];

	assign tgt_raw = prod_q[27:8];

	// pulse attack/decay
	always_comb begin
		if (rise_q) p_raw = 33'(acc_q) + 33'(prod_q) + 33'd32768;
		else        p_raw = 33'(acc_q);
		p_sat = (p_raw[32:16] > 17'hFFFF) ? 16'hFFFF : p_raw[31:16];
		p_new = ((level_q < thr_q) && (p_sat < thr_q)) ? 16'd0 : p_sat;
	end

	// hue difference folded onto the shortest arc
	always_comb begin
		d_raw = $signed({2'b00, hues_q}) - $signed({2'b00, huef_q});
		d_fold = d_raw;
		if (d_raw > 18'sd32768) d_fold = d_raw - 18'sd65536;
		else if (d_raw < -18'sd32768) d_fold = d_raw + 18'sd65536;
	end

	assign delta = 17'((prod_q + PW'(32768)) >> 16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 4'd4;
			thr_q    <= 16'd655;
			sens_q   <= 11'd384;
			react_q  <= 12'd1280;
			att_q    <= 16'd26214;
			dec_q    <= 16'd62259;
			huef_q   <= 16'd0;
			hues_q   <= 16'd43254;
			sum_q    <= '0;
			ptr_q    <= '0;
			frames_q <= '0;
			bl_q     <= abt_pkg::BL_RESET;
			pulse_q  <= '0;
			for (int i = 0; i < abt_pkg::HISTORY_DEPTH; i++) ring_q[i] <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					abt_pkg::REG_MODE:   mode_q  <= cfg_data[3:0];
					abt_pkg::REG_THRESH: thr_q   <= cfg_data;
					abt_pkg::REG_SENS:   sens_q  <= cfg_data[10:0];
					abt_pkg::REG_REACT:  react_q <= cfg_data[11:0];
					abt_pkg::REG_ATTACK: att_q   <= cfg_data;
					abt_pkg::REG_DECAY:  dec_q   <= cfg_data;
					abt_pkg::REG_HUE1:   huef_q  <= cfg_data;
					abt_pkg::REG_HUE2:   hues_q  <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.op == abt_pkg::OP_RING) begin
				sum_q <= sum_q - SW'(ring_q[ptr_q]) + SW'(level_q);
				ring_q[ptr_q] <= level_q;
				ptr_q <= (ptr_q == PTW'(abt_pkg::HISTORY_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
				if (frames_q != 8'hFF) frames_q <= frames_q + 8'd1;
			end
			if (cmd.op == abt_pkg::OP_BEAT) begin
				bl_q <= nb;
				if ((frames_q >= 8'(abt_pkg::MIN_BEAT_GAP)) && (20'(level_q) > nb) &&
				    (level_q > abt_pkg::BEAT_FLOOR))
					frames_q <= '0;
			end
			if (cmd.op == abt_pkg::OP_PULSE) pulse_q <= p_new;
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (mul_en) prod_q <= prod_d;
		if (cmd.load) begin
			lo_q   <= low_band;
			mid_q  <= mid_band;
			hi_q   <= high_band;
			bsum_q <= 18'(low_band) + 18'(mid_band) + 18'(high_band);
		end
		case (cmd.op)
			abt_pkg::OP_SEL:   x_q <= x_sel;
			abt_pkg::OP_CUBE:  sq_q <= prod_q[31:16];
			abt_pkg::OP_LEVEL: level_q <= level_d;
			abt_pkg::OP_BL:    t_q <= prod_q[26:8];
			abt_pkg::OP_T2:    acc_q <= prod_q;
			abt_pkg::OP_BEAT:  beat_q <= (frames_q >= 8'(abt_pkg::MIN_BEAT_GAP)) &&
			                             (20'(level_q) > nb) && (level_q > abt_pkg::BEAT_FLOOR);
			abt_pkg::OP_TGT:   tgt_q <= (tgt_raw > 20'hFFFF) ? 16'hFFFF : tgt_raw[15:0];
			abt_pkg::OP_P1:    rise_q <= tgt_q > pulse_q;
			abt_pkg::OP_P2:    acc_q <= prod_q;
			abt_pkg::OP_PULSE: begin
				dneg_q <= d_fold < 0;
				dabs_q <= (d_fold < 0) ? 16'(-d_fold) : 16'(d_fold);
			end
			abt_pkg::OP_HUE:   hue_q <= dneg_q ? huef_q - delta[15:0] : huef_q + delta[15:0];
			default: ;
		endcase
		if (cmd.publish) begin
			shaped_q <= level_q;
			beat_o_q <= beat_q;
			pls_q    <= pulse_q;
			hueo_q   <= hue_q;
		end
	end

	assign shaped_level = shaped_q;
	assign beat_flag    = beat_o_q;
	assign pulse_level  = pls_q;
	assign hue_out      = hueo_q;

endmodule

FILE: src/audio_beat_and_pulse_tracker.sv
// Top level of the audio beat and pulse tracker.
// Instantiates abt_ctrl and abt_dp; depends on abt_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one frame of three Q0.16 band
//   levels at a time. Output channel (out_valid/out_ready) returns one
//   result per frame: shaped level, beat flag, pulse level and hue.
//   Config port: cfg_we writes cfg_data into the register at cfg_index
//   (0 mode, 1 threshold, 2 sensitivity, 3 reactivity, 4 attack, 5 decay,
//   6 first hue, 7 second hue) in the same edge; write only while idle.
// Sequencing:
//   After a frame is accepted, the sequencer runs 18 ops, one per cycle,
//   through a single shared multiplier and its product register, then
//   loads the output register in its publish state. No new frame is taken
//   until the previous frame's result has been published.
// Reset (arst_n low, async): config registers go to defaults, the energy
//   ring and running sum clear, adaptive threshold goes to 0.1, pulse to 0.
// Stall: a result sits in the output register until taken; the next frame
//   may be accepted and processed meanwhile, and the sequencer waits
//   before publishing only if the previous result is still unclaimed.
module audio_beat_and_pulse_tracker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] low_band,
	input  logic [15:0] mid_band,
	input  logic [15:0] high_band,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] shaped_level,
	output logic        beat_flag,
	output logic [15:0] pulse_level,
	output logic [15:0] hue_out,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	abt_pkg::cmd_t cmd;

	abt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	abt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.low_band     (low_band),
		.mid_band     (mid_band),
		.high_band    (high_band),
		.shaped_level (shaped_level),
		.beat_flag    (beat_flag),
		.pulse_level  (pulse_level),
		.hue_out      (hue_out)
	);

endmodule

FILE: src/abt_chk.sv
// Port-level checks for the beat tracker, bound onto the top level.
// Depends only on the top level's ports.
module abt_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] shaped_level,
	input logic        beat_flag,
	input logic [15:0] pulse_level,
	input logic [15:0] hue_out
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(shaped_level) &&
		$stable(beat_flag) && $stable(pulse_level) && $stable(hue_out))
		else $error("stalled result changed");

	// a taken frame keeps the input closed while it is worked on
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted during work");

	// beats need a level above the floor
	a_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (shaped_level <= 16'd3276) |-> !beat_flag)
		else $error("beat below floor");

	// an idle input stays open until a frame shows up
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && !in_valid |=> in_ready)
		else $error("input closed while idle");

endmodule

bind audio_beat_and_pulse_tracker abt_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.shaped_level (shaped_level),
	.beat_flag    (beat_flag),
	.pulse_level  (pulse_level),
	.hue_out      (hue_out)
);
